/* hdl/cc20_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_pkg: shared types and constants
// Word constants, register indexes and the byte queue entry type.
// ----------------------------------------------------------------------------
package cc20_pkg;

  localparam logic [31:0] SIGMA0 = 32'h61707865;
  localparam logic [31:0] SIGMA1 = 32'h3320646e;
  localparam logic [31:0] SIGMA2 = 32'h79622d32;
  localparam logic [31:0] SIGMA3 = 32'h6b206574;

  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 64;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_KEY01 = 3'd0,
    REG_KEY23 = 3'd1,
    REG_KEY45 = 3'd2,
    REG_KEY67 = 3'd3,
    REG_NONCE = 3'd4
  } cfg_reg_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } byte_item_t;

  function automatic logic [31:0] rotl(input logic [31:0] v, input int n);
    rotl = (v << n) | (v >> (32 - n));
  endfunction

endpackage

/* hdl/cc20_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_byte_if: valid/ready byte channel
// Carries one data byte and its last flag.
// ----------------------------------------------------------------------------
interface cc20_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  logic       last;
  modport source (output valid, output data, output last, input ready);
  modport sink (input valid, input data, input last, output ready);
endinterface

/* hdl/cc20_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_front: input byte queue
// Accepts bytes into a four-entry queue that feeds the keystream back end.
// ----------------------------------------------------------------------------
module cc20_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  cc20_pkg::byte_item_t in_item,
  output logic                q_valid,
  output cc20_pkg::byte_item_t q_item,
  input  logic                q_pop
);
  import cc20_pkg::*;

  byte_item_t slot_r [4];
  logic [1:0] wr_r, wr_nxt, rd_r, rd_nxt;
  logic [2:0] cnt_r, cnt_nxt;
  logic       push;

  assign in_ready = (cnt_r != 3'd4);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 3'd0);
  assign q_item   = slot_r[rd_r];

  always_comb begin
    wr_nxt  = wr_r + 2'(push);
    rd_nxt  = rd_r + 2'(q_pop);
    cnt_nxt = cnt_r + 3'(push) - 3'(q_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
    if (push) slot_r[wr_r] <= in_item;
  end
endmodule

/* hdl/cc20_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cc20_core: ChaCha20 block function
// One column or diagonal round per cycle; 20 rounds then feed-forward add.
// ----------------------------------------------------------------------------
module cc20_core (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start,
  input  logic [511:0] init,
  output logic         done,
  output logic [511:0] ks
);
  import cc20_pkg::*;

  logic [31:0] w_r [16];
  logic [31:0] w_nxt [16];
  logic [4:0]  rnd_r;
  logic        busy_r;

  function automatic logic [127:0] qr(input logic [127:0] x);
    logic [31:0] a, b, c, d;
    a = x[31:0]; b = x[63:32]; c = x[95:64]; d = x[127:96];
    a = a + b; d = rotl(d ^ a, 16);
    c = c + d; b = rotl(b ^ c, 12);
    a = a + b; d = rotl(d ^ a, 8);
    c = c + d; b = rotl(b ^ c, 7);
    qr = {d, c, b, a};
  endfunction

  always_comb begin
    logic [127:0] t;
    for (int i = 0; i < 16; i++) w_nxt[i] = w_r[i];
    for (int j = 0; j < 4; j++) begin
      if (!rnd_r[0]) begin
        t = qr({w_r[12+j], w_r[8+j], w_r[4+j], w_r[j]});
        w_nxt[j] = t[31:0]; w_nxt[4+j] = t[63:32];
        w_nxt[8+j] = t[95:64]; w_nxt[12+j] = t[127:96];
      end else begin
        t = qr({w_r[12+((j+3)%4)], w_r[8+((j+2)%4)], w_r[4+((j+1)%4)], w_r[j]});
        w_nxt[j] = t[31:0]; w_nxt[4+((j+1)%4)] = t[63:32];
        w_nxt[8+((j+2)%4)] = t[95:64]; w_nxt[12+((j+3)%4)] = t[127:96];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      rnd_r  <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        rnd_r  <= '0;
      end else if (busy_r) begin
        rnd_r <= rnd_r + 5'd1;
        if (rnd_r == 5'd19) begin
          busy_r <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
    if (start) begin
      for (int i = 0; i < 16; i++) w_r[i] <= init[32*i +: 32];
    end else if (busy_r) begin
      for (int i = 0; i < 16; i++) w_r[i] <= w_nxt[i];
    end
  end

  always_comb begin
    for (int i = 0; i < 16; i++) ks[32*i +: 32] = w_r[i] + init[32*i +: 32];
  end
endmodule

/* hdl/chacha20_stream_xor.sv */
`timescale 1ns / 1ps
// Each byte is popped from the queue, XORed with the stored keystream and
// held in the output register; byte 0 of a block first waits for the 20
// one-round-per-cycle steps of the block unit. Throughput: one byte per
// cycle within a block while the output is not stalled. A four-entry queue
// decouples input from the block unit. Reset (rst_n, synchronous, low):
// counter, position and handshakes clear; key and nonce clear to zero.
// ----------------------------------------------------------------------------
// chacha20_stream_xor: ChaCha20 byte stream XOR
// 64-bit nonce and counter variant; one byte in, one byte out.
// ----------------------------------------------------------------------------
module chacha20_stream_xor (
  input  logic                             clk,
  input  logic                             rst_n,
  cc20_byte_if.sink                        in_ch,
  cc20_byte_if.source                      out_ch,
  input  logic                             cfg_we,
  input  logic [cc20_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [cc20_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import cc20_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_GEN  = 3'b010,
    ST_RUN  = 3'b100
  } state_t;

  logic [63:0]  key_r [4];
  logic [63:0]  nonce_r;
  logic [63:0]  ctr_r;
  logic [5:0]   pos_r;
  state_t       st_r;
  logic [511:0] ks_r;
  logic [511:0] init;
  logic [511:0] ks;
  logic         core_done, core_start;
  logic         q_valid, q_pop;
  byte_item_t   q_item, in_item;
  logic         ov_r;
  logic [7:0]   od_r;
  logic         ol_r;
  logic         out_free;

  assign in_item = '{data: in_ch.data, last: in_ch.last};

  cc20_front u_front (
    .clk, .rst_n,
    .in_valid (in_ch.valid), .in_ready (in_ch.ready), .in_item,
    .q_valid, .q_item, .q_pop
  );

  always_comb begin
    init = {nonce_r, ctr_r, key_r[3], key_r[2], key_r[1], key_r[0],
            SIGMA3, SIGMA2, SIGMA1, SIGMA0};
  end

  cc20_core u_core (
    .clk, .rst_n, .start (core_start), .init, .done (core_done), .ks
  );

  assign out_free   = !ov_r || out_ch.ready;
  assign core_start = (st_r == ST_IDLE) && q_valid;
  assign q_pop      = (st_r == ST_RUN) && q_valid && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      nonce_r <= '0;
      ctr_r   <= '0;
      pos_r   <= '0;
      st_r    <= ST_IDLE;
      ov_r    <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_KEY01: key_r[0] <= cfg_data;
          REG_KEY23: key_r[1] <= cfg_data;
          REG_KEY45: key_r[2] <= cfg_data;
          REG_KEY67: key_r[3] <= cfg_data;
          REG_NONCE: nonce_r  <= cfg_data;
          default: ;
        endcase
      end
      if (out_ch.ready) ov_r <= 1'b0;
      unique case (st_r)
        ST_IDLE: if (core_start) st_r <= ST_GEN;
        ST_GEN:  if (core_done) st_r <= ST_RUN;
        ST_RUN: begin
          if (q_pop) begin
            ov_r <= 1'b1;
            if (pos_r == 6'd63) begin
              ctr_r <= ctr_r + 64'd1;
              pos_r <= '0;
              st_r  <= ST_IDLE;
            end else if (q_item.last) begin
              pos_r <= '0;
              st_r  <= ST_IDLE;
            end else begin
              pos_r <= pos_r + 6'd1;
            end
          end
        end
        default: st_r <= ST_IDLE;
      endcase
    end
    if (core_done) ks_r <= ks;
    if (q_pop) begin
      od_r <= q_item.data ^ ks_r[8*pos_r +: 8];
      ol_r <= q_item.last;
    end
  end

  assign out_ch.valid = ov_r;
  assign out_ch.data  = od_r;
  assign out_ch.last  = ol_r;

  // Position only advances while bytes are streamed against a finished block.
  a_pos_run: assert property (@(posedge clk) disable iff (!rst_n)
    (pos_r != $past(pos_r)) |-> $past(st_r == ST_RUN))
    else $error("position moved outside run state");
  a_ctr_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && (ctr_r != $past(ctr_r)) |-> ($past(pos_r) == 6'd63))
    else $error("counter advanced before block end");
  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && !out_ch.ready) |=> (ov_r && $stable(od_r)))
    else $error("output dropped while stalled");
  a_done_gen: assert property (@(posedge clk) disable iff (!rst_n)
    core_done |-> (st_r == ST_GEN))
    else $error("block finished outside generation");
endmodule

/* sim/chacha20_stream_xor_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// chacha20_stream_xor_tb: self-checking bench for the ChaCha20 byte XOR block
// Streams bytes and message framing through the block, predicts each output
// byte from an in-bench ChaCha20 keystream model and compares in order.
// ----------------------------------------------------------------------------
module chacha20_stream_xor_tb;
  import cc20_pkg::*;

  localparam int IDLE_LIMIT = 4000;
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [7:0] data;
    logic       last;
    bit         known;
    logic [7:0] exp_data;
  } stim_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  cc20_byte_if in_ch ();
  cc20_byte_if out_ch ();

  chacha20_stream_xor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // predictor state
  logic [63:0] key_q[4];
  logic [63:0] nonce_q;
  logic [63:0] ctr_q;
  logic [5:0]  pos_q;
  logic [31:0] ks_words[16];

  byte_item_t expected_bytes[$];
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int idle_cycles = 0;

  function automatic logic [31:0] rol32(logic [31:0] v, int n);
    return (v << n) | (v >> (32 - n));
  endfunction

  function automatic void quarter(inout logic [31:0] w[16], input int a, b, c, d);
    w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 16);
    w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 12);
    w[a] += w[b]; w[d] = rol32(w[d] ^ w[a], 8);
    w[c] += w[d]; w[b] = rol32(w[b] ^ w[c], 7);
  endfunction

  function automatic void compute_keystream();
    logic [31:0] init[16];
    logic [31:0] w[16];
    init[0] = SIGMA0; init[1] = SIGMA1; init[2] = SIGMA2; init[3] = SIGMA3;
    for (int i = 0; i < 4; i++) begin
      init[4 + 2 * i] = key_q[i][31:0];
      init[5 + 2 * i] = key_q[i][63:32];
    end
    init[12] = ctr_q[31:0];   init[13] = ctr_q[63:32];
    init[14] = nonce_q[31:0]; init[15] = nonce_q[63:32];
    w = init;
    for (int r = 0; r < 10; r++) begin
      quarter(w, 0, 4, 8, 12);  quarter(w, 1, 5, 9, 13);
      quarter(w, 2, 6, 10, 14); quarter(w, 3, 7, 11, 15);
      quarter(w, 0, 5, 10, 15); quarter(w, 1, 6, 11, 12);
      quarter(w, 2, 7, 8, 13);  quarter(w, 3, 4, 9, 14);
    end
    for (int i = 0; i < 16; i++) ks_words[i] = w[i] + init[i];
  endfunction

  function automatic byte_item_t predict_cipher_byte(logic [7:0] d, logic l);
    byte_item_t r;
    if (pos_q == 6'd0) compute_keystream();
    r.data = d ^ ks_words[pos_q[5:2]][8 * pos_q[1:0] +: 8];
    r.last = l;
    if (pos_q == 6'd63) begin
      ctr_q += 64'd1;
      pos_q = 6'd0;
    end else if (l) begin
      pos_q = 6'd0;
    end else begin
      pos_q = pos_q + 6'd1;
    end
    return r;
  endfunction

  initial begin
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    in_ch.last = 1'b0;
    out_ch.ready = 1'b0;
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready) begin
        expected_bytes.push_back(predict_cipher_byte(in_ch.data, in_ch.last));
      end
      if (out_ch.valid && out_ch.ready) begin
        if (expected_bytes.size() == 0) begin
          $display("%0t: unexpected output, expected none actual data=%h last=%b",
                   $time, out_ch.data, out_ch.last);
          errors++;
        end else begin
          byte_item_t e;
          e = expected_bytes.pop_front();
          if (e.data !== out_ch.data || e.last !== out_ch.last) begin
            $display("%0t: mismatch expected data=%h last=%b actual data=%h last=%b",
                     $time, e.data, e.last, out_ch.data, out_ch.last);
            errors++;
          end
        end
      end
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
        idle_cycles <= 0;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("** chacha20_stream_xor: FAILED **");
      $finish;
    end
  end

  // hold valid across back-to-back transfers; drop it only to idle
  task automatic send_byte(logic [7:0] d, logic l);
    if ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_ch.valid <= 1'b1;
    in_ch.data <= d;
    in_ch.last <= l;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
  endtask

  task automatic wait_drained();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (expected_bytes.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(cfg_reg_t idx, logic [63:0] v);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= v;
    @(posedge clk);
    if (idx == REG_NONCE) nonce_q = v;
    else key_q[idx] = v;
  endtask

  task automatic load_key_nonce(logic [63:0] k0, k1, k2, k3, n);
    write_reg(REG_KEY01, k0);
    write_reg(REG_KEY23, k1);
    write_reg(REG_KEY45, k2);
    write_reg(REG_KEY67, k3);
    write_reg(REG_NONCE, n);
    cfg_we <= 1'b0;
  endtask

  function automatic logic [63:0] rand64();
    return {$urandom(), $urandom()};
  endfunction

  // random messages: mostly partial, some spanning several blocks
  task automatic send_messages(int n_bytes);
    int sent;
    int len;
    sent = 0;
    while (sent < n_bytes) begin
      case ($urandom_range(3))
        0: len = $urandom_range(1, 8);
        1: len = $urandom_range(9, 63);
        2: len = 64;
        default: len = $urandom_range(65, 200);
      endcase
      for (int i = 0; i < len; i++) begin
        send_byte(8'($urandom_range(255)), (i == len - 1) || ($urandom_range(49) == 0));
      end
      sent += len;
    end
  endtask

  stim_row_t directed[$];

  initial begin
    key_q = '{default: '0};
    nonce_q = '0;
    ctr_q = '0;
    pos_q = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // zero key, zero nonce: first keystream bytes are 76 b8 e0 ad
    directed.push_back('{8'h00, 1'b0, 1, 8'h76});
    directed.push_back('{8'hff, 1'b0, 1, 8'h47});
    directed.push_back('{8'h00, 1'b0, 1, 8'he0});
    directed.push_back('{8'hff, 1'b1, 1, 8'h52});
    // partial ending restarts at the same counter
    directed.push_back('{8'h00, 1'b1, 1, 8'h76});
    directed.push_back('{8'h80, 1'b0, 0, 8'h00});
    directed.push_back('{8'h01, 1'b0, 0, 8'h00});
    foreach (directed[i]) begin
      send_byte(directed[i].data, directed[i].last);
    end
    wait_drained();
    // full block boundaries, last on byte 63 and without last
    for (int i = 0; i < 128; i++) send_byte(8'($urandom_range(255)), i == 63);
    send_byte(8'h55, 1'b1);
    wait_drained();

    // directed known values: rows with typed expectations
    // checked already by the predictor; confirm table against it
    // (predictor reset state equals the table's assumptions)

    // extreme key and nonce
    load_key_nonce('1, '1, '1, '1, '1);
    for (int i = 0; i < 70; i++) send_byte(i[0] ? 8'hff : 8'h00, 1'b0);
    send_byte(8'haa, 1'b1);
    wait_drained();

    send_idle_pct = 17; recv_idle_pct = 84;
    load_key_nonce(rand64(), rand64(), rand64(), rand64(), rand64());
    send_messages(500);
    wait_drained();

    send_idle_pct = 84; recv_idle_pct = 17;
    load_key_nonce(rand64(), 64'h0, rand64(), 64'hffff_ffff_ffff_ffff, 64'h0);
    send_messages(500);
    wait_drained();

    send_idle_pct = 0; recv_idle_pct = 0;
    load_key_nonce(rand64(), rand64(), rand64(), rand64(), rand64());
    send_messages(500);
    wait_drained();

    if (errors == 0) begin
      $display("** chacha20_stream_xor: PASSED **");
    end else begin
      $display("** chacha20_stream_xor: FAILED **");
    end
    $finish;
  end

  // check typed expectations of the directed table at acceptance
  int dir_idx = 0;
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready && dir_idx < directed.size()) begin
      if (directed[dir_idx].known && out_ch.data !== directed[dir_idx].exp_data) begin
        $display("%0t: directed row %0d expected %h actual %h", $time, dir_idx,
                 directed[dir_idx].exp_data, out_ch.data);
        errors++;
      end
      dir_idx <= dir_idx + 1;
    end
  end

endmodule

/* files.f */
hdl/cc20_pkg.sv
hdl/cc20_if.sv
hdl/cc20_front.sv
hdl/cc20_core.sv
hdl/chacha20_stream_xor.sv
sim/chacha20_stream_xor_tb.sv
